// ----- sv/competitive_learning_clusterer_unit_assert.svh -----
// Assertion macros for the clusterer block
`ifndef COMPETITIVE_LEARNING_CLUSTERER_UNIT_ASSERT_SVH
`define COMPETITIVE_LEARNING_CLUSTERER_UNIT_ASSERT_SVH
// implication checked every clock, quiet during reset
`define CLC_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
// next-cycle implication
`define CLC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`endif

// ----- sv/clc_pkg.sv -----
// Shared types and constants of the clusterer
`default_nettype none
package clc_pkg;
	localparam int MaxSamples = 32;
	localparam int VectorLength = 4;
	localparam int NElem = 4;
	localparam int SaW = $clog2(MaxSamples);
	localparam int CntW = $clog2(MaxSamples + 1);
	localparam logic [2:0] RegInitialRate = 3'd0;
	localparam logic [2:0] RegDecayFactor = 3'd1;
	localparam logic [2:0] RegStopRate = 3'd2;
	localparam logic ActLoad = 1'b0;

	typedef struct packed {
		logic       action;
		logic [7:0] elem0;
		logic [7:0] elem1;
		logic [7:0] elem2;
		logic [7:0] elem3;
	} in_item_t;

	typedef struct packed {
		logic        kind;
		logic [5:0]  index;
		logic        category;
		logic [23:0] weight0;
		logic [23:0] weight1;
		logic [23:0] weight2;
		logic [23:0] weight3;
		logic [15:0] epochs;
		logic        last;
	} out_item_t;

	typedef struct packed {
		logic [2:0]  index;
		logic [15:0] data;
	} cfg_item_t;

	// controller -> datapath
	typedef struct packed {
		logic            store;      // write sample at count
		logic            clr_count;
		logic            start_run;  // load rate, set epochs to one
		logic            epoch_inc;
		logic            rd;         // read sample at idx
		logic [SaW-1:0]  idx;
		logic            calc;       // compute distances of read sample
		logic            winsel;     // register winner
		logic            upd;        // move winner
		logic            decay;
		logic            emit_cat;
		logic            emit_row;
		logic            row;
	} dp_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic [CntW-1:0] count;
		logic            rate_above;
	} dp_sts_t;

	function automatic logic [23:0] w_init(input logic c, input int j);
		logic [23:0] r;
		r = 24'd0;
		case ({c, j[1:0]})
			3'd0: r = 24'd13107;
			3'd1: r = 24'd39322;
			3'd2: r = 24'd32768;
			3'd3: r = 24'd58982;
			3'd4: r = 24'd52429;
			3'd5: r = 24'd26214;
			3'd6: r = 24'd45875;
			default: r = 24'd19661;
		endcase
		return r;
	endfunction
endpackage
`default_nettype wire

// ----- sv/clc_if.sv -----
// Valid/ready channel interfaces
`default_nettype none
interface clc_in_if (input logic clk);
	logic valid;
	logic ready;
	clc_pkg::in_item_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface clc_out_if (input logic clk);
	logic valid;
	logic ready;
	clc_pkg::out_item_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface clc_cfg_if (input logic clk);
	logic valid;
	logic ready;
	clc_pkg::cfg_item_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ----- sv/clc_ram.sv -----
// Generic simple dual-port RAM (one write port, one read port) with registered read
`default_nettype none
module clc_ram #(
	parameter int Width = 32,
	parameter int Depth = 32
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(Depth)-1:0] waddr,
	input  wire logic [Width-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(Depth)-1:0] raddr,
	output logic      [Width-1:0]         rdata
);
	logic [Width-1:0] mem_q [Depth];

	always_ff @(posedge clk) begin
		if (we) mem_q[waddr] <= wdata;
		if (re) rdata <= mem_q[raddr];
	end
endmodule
`default_nettype wire

// ----- sv/clc_datapath.sv -----
// Sample store, weights, distance, update and rate arithmetic
`default_nettype none
module clc_datapath (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire clc_pkg::dp_cmd_t     cmd,
	input  wire clc_pkg::in_item_t    in_item,
	input  wire logic [15:0]          initial_rate,
	input  wire logic [15:0]          decay_factor,
	input  wire logic [15:0]          stop_rate,
	output clc_pkg::dp_sts_t          sts,
	output clc_pkg::out_item_t        res
);
	import clc_pkg::*;

	logic [CntW-1:0] count_q;
	logic [23:0] w_q [2][NElem];
	logic [15:0] rate_q;
	logic [15:0] epoch_q;
	logic [31:0] rd_data;
	logic [31:0] smp_q;
	logic        win_q;
	logic [47:0] sq_s1 [2][NElem];
	logic [49:0] sum0, sum1;
	logic [31:0] rate_prod;
	logic        wr_en;

	assign wr_en = cmd.store && (count_q < CntW'(MaxSamples));

	clc_ram #(.Width(32), .Depth(MaxSamples)) u_store (
		.clk(clk), .we(wr_en), .waddr(count_q[SaW-1:0]),
		.wdata({in_item.elem3, in_item.elem2, in_item.elem1, in_item.elem0}),
		.re(cmd.rd), .raddr(cmd.idx), .rdata(rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cmd.clr_count) begin
			count_q <= '0;
		end else if (wr_en) begin
			count_q <= count_q + 1'b1;
		end
	end

	// squared distances per element, one multiplier per lane
	always_ff @(posedge clk) begin
		if (cmd.calc) begin
			smp_q <= rd_data;
			for (int c = 0; c < 2; c++) begin
				for (int j = 0; j < NElem; j++) begin
					logic [23:0] x;
					logic [23:0] d;
					x = {rd_data[8*j +: 8], 16'd0};
					d = (w_q[c][j] >= x) ? w_q[c][j] - x : x - w_q[c][j];
					sq_s1[c][j] <= (j < VectorLength) ? 48'(d) * 48'(d) : 48'd0;
				end
			end
		end
	end

	always_comb begin
		sum0 = '0;
		sum1 = '0;
		for (int j = 0; j < NElem; j++) begin
			sum0 = sum0 + 50'(sq_s1[0][j]);
			sum1 = sum1 + 50'(sq_s1[1][j]);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.winsel) win_q <= (sum0 > sum1);
	end

	assign rate_prod = rate_q * decay_factor;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int c = 0; c < 2; c++)
				for (int j = 0; j < NElem; j++)
					w_q[c][j] <= w_init(c[0], j);
			rate_q <= '0;
			epoch_q <= '0;
		end else begin
			if (cmd.start_run) rate_q <= initial_rate;
			// a run item opens its first epoch
			if (cmd.start_run) begin
				epoch_q <= 16'd1;
			end else if (cmd.epoch_inc && epoch_q != 16'hFFFF) begin
				epoch_q <= epoch_q + 1'b1;
			end
			if (cmd.decay) rate_q <= rate_prod[31:16];
			if (cmd.upd) begin
				for (int j = 0; j < NElem; j++) begin
					logic [23:0] x;
					logic [23:0] w;
					logic [39:0] st;
					w = w_q[win_q][j];
					x = {smp_q[8*j +: 8], 16'd0};
					if (j < VectorLength) begin
						if (x >= w) begin
							st = rate_q * (x - w);
							w_q[win_q][j] <= w + st[39:16];
						end else begin
							st = rate_q * (w - x);
							w_q[win_q][j] <= w - st[39:16];
						end
					end
				end
			end
		end
	end

	assign sts.count = count_q;
	assign sts.rate_above = rate_q > stop_rate;

	always_comb begin
		res = '0;
		res.epochs = epoch_q;
		if (cmd.emit_cat) begin
			res.index = 6'(cmd.idx);
			res.category = win_q;
		end else if (cmd.emit_row) begin
			res.kind = 1'b1;
			res.index = {5'd0, cmd.row};
			res.last = cmd.row;
			res.weight0 = (VectorLength > 0) ? w_q[cmd.row][0] : 24'd0;
			res.weight1 = (VectorLength > 1) ? w_q[cmd.row][1] : 24'd0;
			res.weight2 = (VectorLength > 2) ? w_q[cmd.row][2] : 24'd0;
			res.weight3 = (VectorLength > 3) ? w_q[cmd.row][3] : 24'd0;
		end
	end
endmodule
`default_nettype wire

// ----- sv/clc_ctrl.sv -----
// Run sequencer for the clusterer
`default_nettype none
module clc_ctrl (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	input  wire logic             in_action,
	output logic                  in_ready,
	input  wire logic             out_taken,
	output logic                  res_load,
	input  wire clc_pkg::dp_sts_t sts,
	output clc_pkg::dp_cmd_t      cmd
);
	import clc_pkg::*;

	typedef enum logic [8:0] {
		S_IDLE  = 9'b000000001,
		S_RD    = 9'b000000010,
		S_DIST  = 9'b000000100,
		S_WIN   = 9'b000001000,
		S_UPD   = 9'b000010000,
		S_DECAY = 9'b000100000,
		S_CHECK = 9'b001000000,
		S_EMIT  = 9'b010000000,
		S_WAIT  = 9'b100000000
	} state_t;

	state_t state_q;
	logic [SaW-1:0] idx_q;
	logic classify_q;   // second pass: categories only
	logic row_q;
	logic rows_q;       // emitting weight rows

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			idx_q <= '0;
			classify_q <= 1'b0;
			row_q <= 1'b0;
			rows_q <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_valid && in_action != ActLoad) begin
						idx_q <= '0;
						classify_q <= 1'b0;
						state_q <= S_RD;
					end
				end
				S_RD: begin
					if (CntW'(idx_q) >= sts.count) begin
						if (classify_q) begin
							rows_q <= 1'b1;
							row_q <= 1'b0;
							state_q <= S_EMIT;
						end else begin
							state_q <= S_DECAY;
						end
					end else begin
						state_q <= S_DIST;
					end
				end
				S_DIST: state_q <= S_WIN;
				S_WIN: state_q <= classify_q ? S_EMIT : S_UPD;
				S_UPD: begin
					idx_q <= idx_q + 1'b1;
					state_q <= (CntW'(idx_q) == CntW'(MaxSamples - 1)) ? S_DECAY : S_RD;
				end
				S_DECAY: state_q <= S_CHECK;
				S_CHECK: begin
					idx_q <= '0;
					if (sts.rate_above) begin
						state_q <= S_RD;
					end else begin
						classify_q <= 1'b1;
						state_q <= S_RD;
					end
				end
				S_EMIT: state_q <= S_WAIT;
				S_WAIT: begin
					if (out_taken) begin
						if (rows_q) begin
							if (row_q) begin
								rows_q <= 1'b0;
								state_q <= S_IDLE;
							end else begin
								row_q <= 1'b1;
								state_q <= S_EMIT;
							end
						end else begin
							idx_q <= idx_q + 1'b1;
							if (CntW'(idx_q) == CntW'(MaxSamples - 1)) begin
								rows_q <= 1'b1;
								row_q <= 1'b0;
								state_q <= S_EMIT;
							end else begin
								state_q <= S_RD;
							end
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_comb begin
		cmd = '0;
		cmd.idx = idx_q;
		cmd.row = row_q;
		in_ready = (state_q == S_IDLE);
		res_load = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.store = (in_action == ActLoad);
					cmd.start_run = (in_action != ActLoad);
					cmd.epoch_inc = (in_action != ActLoad);
				end
			end
			S_RD: cmd.rd = 1'b1;
			S_DIST: cmd.calc = 1'b1;
			S_WIN: cmd.winsel = 1'b1;
			S_UPD: cmd.upd = 1'b1;
			S_DECAY: cmd.decay = 1'b1;
			S_CHECK: cmd.epoch_inc = sts.rate_above;
			S_EMIT: begin
				res_load = 1'b1;
				cmd.emit_cat = !rows_q;
				cmd.emit_row = rows_q;
				cmd.clr_count = rows_q && row_q;
			end
			S_WAIT: ;
			default: ;
		endcase
	end
endmodule
`default_nettype wire

// ----- sv/competitive_learning_clusterer_unit.sv -----
// Top level of the two-cluster competitive learning clusterer
// channel | dir | payload
// in      | in  | action, elem0..elem3
// out     | out | kind, index, category, weight0..3, epochs, last
// cfg     | in  | index, data (initial_rate, decay_factor, stop_rate)
// A load is stored while idle. Each run epoch reads each stored sample from the
// registered store and takes the distance, winner and update steps for it, then
// the decay and rate check. Reporting gives one category per sample, then two
// weight rows; the input stalls from a run item until the last row is taken.
// Reset restores the initial weights and register values.
`default_nettype none
module competitive_learning_clusterer_unit (
	input wire logic  clk,
	input wire logic  arst_n,
	clc_in_if.sink    in,
	clc_out_if.source out,
	clc_cfg_if.sink   cfg
);
	import clc_pkg::*;

	logic [15:0] initial_rate_q, decay_factor_q, stop_rate_q;
	dp_cmd_t cmd;
	dp_sts_t sts;
	out_item_t res;
	logic res_load;
	logic ovalid_q;
	out_item_t odata_q;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			initial_rate_q <= 16'd32768;
			decay_factor_q <= 16'd62915;
			stop_rate_q <= 16'd655;
		end else if (cfg.valid) begin
			unique case (cfg.data.index)
				RegInitialRate: initial_rate_q <= cfg.data.data;
				RegDecayFactor: decay_factor_q <= cfg.data.data;
				RegStopRate: stop_rate_q <= cfg.data.data;
				default: ;
			endcase
		end
	end

	clc_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in.valid), .in_action(in.data.action),
		.in_ready(in.ready), .out_taken(out.ready && ovalid_q), .res_load(res_load),
		.sts(sts), .cmd(cmd)
	);

	clc_datapath u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .in_item(in.data),
		.initial_rate(initial_rate_q), .decay_factor(decay_factor_q),
		.stop_rate(stop_rate_q), .sts(sts), .res(res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ovalid_q <= 1'b0;
		end else if (res_load) begin
			ovalid_q <= 1'b1;
		end else if (out.ready) begin
			ovalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_load) odata_q <= res;
	end

	assign out.valid = ovalid_q;
	assign out.data = odata_q;
endmodule
`default_nettype wire

// ----- sv/clc_checker.sv -----
// Port-level checker for the clusterer, bound to the top level
`default_nettype none
`include "competitive_learning_clusterer_unit_assert.svh"
module clc_checker (
	input wire logic            clk,
	input wire logic            arst_n,
	input wire logic            in_ready,
	input wire logic            out_valid,
	input wire logic            out_ready,
	input wire clc_pkg::out_item_t out_data
);
	`CLC_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(out_data))
	`CLC_ASSERT_IMPL(a_no_in_during_out, clk, arst_n, out_valid, !in_ready)
	`CLC_ASSERT_IMPL(a_last_is_row, clk, arst_n, out_valid && out_data.last, out_data.kind && out_data.index == 6'd1)
	`CLC_ASSERT_IMPL(a_cat_no_weights, clk, arst_n, out_valid && !out_data.kind, out_data.weight0 == 24'd0 && !out_data.last)
endmodule

bind competitive_learning_clusterer_unit clc_checker u_checker (
	.clk(clk), .arst_n(arst_n), .in_ready(in.ready),
	.out_valid(out.valid), .out_ready(out.ready), .out_data(out.data)
);
`default_nettype wire
